/* hw/rtl/wicu_pkg.sv */
// Shared types and constants for the window interval coverage unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package wicu_pkg;

    // Register indexes on the configuration port.
    localparam logic REG_WINDOW_START = 1'b0;
    localparam logic REG_WINDOW_END   = 1'b1;

    // Coverage is reported as percent in unsigned 8.8 fixed point.
    localparam int unsigned PCT_SCALE = 25600;
    localparam int unsigned PCT_BITS  = 15;
    localparam int unsigned STEP_BITS = $clog2(PCT_BITS);

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    // Output request layout inside tdata.
    localparam int unsigned OUT_DATA_BITS = 112;

    // One configuration write as seen by the datapath.
    typedef struct packed {
        logic        we;
        logic        index;
        logic [31:0] data;
    } cfg_wr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic read_step;
        logic finish_take;
        logic calc;
        logic mul;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

/* hw/rtl/wicu_ctrl.sv */
// Controller of the window interval coverage unit: the request handshakes and the
// sequence of the finish computation. Depends on wicu_pkg.
module wicu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_finish,
    output logic              m_tvalid,
    input  logic              m_tready,
    output wicu_pkg::cmd_t    cmd,
    input  wicu_pkg::status_t status
);
    import wicu_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CALC = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        s_tready        = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_finish)
                    begin
                        cmd.finish_take = 1'b1;
                        state_next      = ST_CALC;
                    end
                    else
                    begin
                        cmd.read_step = 1'b1;
                    end
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // A finish request starts the computation in the following cycle.
    a_finish_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_finish) |=> (state_reg == ST_CALC))
        else $error("finish request did not start the computation");

    // The last division step hands over to the output stage.
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && status.div_last) |=> (state_reg == ST_DONE))
        else $error("division did not finish after its last step");

    // A loaded result is offered in the next cycle.
    a_load_offered: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not offered");

    // No new request is taken while a finish is being computed.
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_finish) |=> !s_tready)
        else $error("request accepted during finish computation");

endmodule

/* hw/rtl/wicu_dp.sv */
// Datapath of the window interval coverage unit: window registers, walk state,
// the finish arithmetic and a radix-2 divider for the percentage. Depends on wicu_pkg.
module wicu_dp #(
    parameter int unsigned PW = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wicu_pkg::cfg_wr_t                     cfg_wr,
    input  wicu_pkg::cmd_t                        cmd,
    output wicu_pkg::status_t                     status,
    input  logic [31:0]                           read_start,
    input  logic [31:0]                           read_end,
    output logic [PW-1:0]                         window_start,
    output logic [PW-1:0]                         window_end,
    output logic [wicu_pkg::OUT_DATA_BITS-1:0]    out_data
);
    import wicu_pkg::*;

    localparam int unsigned PROD_BITS = PW + PCT_BITS;

    // Configuration and walk state.
    logic [PW-1:0]        ws_reg;
    logic [PW-1:0]        we_reg;
    logic [PW-1:0]        covered_end_reg;
    logic [PW-1:0]        covered_end_next;
    logic [31:0]          gap_sum_reg;
    logic [31:0]          gap_sum_next;
    logic [31:0]          hit_count_reg;
    logic [31:0]          hit_count_next;
    logic                 walk_done_reg;
    logic                 walk_done_next;

    // Finish snapshot and arithmetic.
    logic [31:0]          gap_snap_reg;
    logic [31:0]          hit_snap_reg;
    logic [PW-1:0]        tail_reg;
    logic [PW-1:0]        len_reg;
    logic [PW-1:0]        unc_reg;
    logic [PW-1:0]        covered_reg;
    logic [PW-1:0]        rem_reg;
    logic [PCT_BITS-1:0]  q_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;

    logic [PW-1:0]        rs;
    logic [PW-1:0]        re;
    logic [PW-1:0]        cfg_val;
    logic [32:0]          gap_add;
    logic                 hit;
    logic [PW-1:0]        len_now;
    logic [PW-1:0]        tail_now;
    logic [32:0]          unc_sum;
    logic [PW-1:0]        unc_clamped;
    logic [PROD_BITS-1:0] prod;
    logic [PW:0]          trial;
    logic                 trial_ge;
    logic [PCT_BITS-1:0]  pct;

    assign rs      = read_start[PW-1:0];
    assign re      = read_end[PW-1:0];
    assign cfg_val = cfg_wr.data[PW-1:0];

    // Window registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= '0;
            we_reg <= '0;
        end
        else if (cfg_wr.we)
        begin
            if (cfg_wr.index == REG_WINDOW_START)
            begin
                ws_reg <= cfg_val;
            end
            else
            begin
                we_reg <= cfg_val;
            end
        end
    end

    // One read interval updates the walk state.
    assign gap_add = {1'b0, gap_sum_reg} + 33'(rs - covered_end_reg);
    assign hit     = ((ws_reg <= rs) && (rs <= we_reg)) || ((ws_reg <= re) && (re <= we_reg));

    always_comb
    begin
        covered_end_next = covered_end_reg;
        gap_sum_next     = gap_sum_reg;
        hit_count_next   = hit_count_reg;
        walk_done_next   = walk_done_reg;
        if (cfg_wr.we)
        begin
            // A register write restarts the walk from the new window start.
            covered_end_next = (cfg_wr.index == REG_WINDOW_START) ? cfg_val : ws_reg;
            gap_sum_next     = '0;
            hit_count_next   = '0;
            walk_done_next   = 1'b0;
        end
        else if (cmd.finish_take)
        begin
            covered_end_next = ws_reg;
            gap_sum_next     = '0;
            hit_count_next   = '0;
            walk_done_next   = 1'b0;
        end
        else if (cmd.read_step && !walk_done_reg)
        begin
            if (rs > we_reg)
            begin
                // First read beyond the window ends the walk.
                walk_done_next = 1'b1;
            end
            else
            begin
                if (rs > covered_end_reg)
                begin
                    gap_sum_next = gap_add[32] ? MAX32 : gap_add[31:0];
                end
                if (re > covered_end_reg)
                begin
                    covered_end_next = re;
                end
                if (hit && (hit_count_reg != MAX32))
                begin
                    hit_count_next = hit_count_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            covered_end_reg <= '0;
            gap_sum_reg     <= '0;
            hit_count_reg   <= '0;
            walk_done_reg   <= 1'b0;
        end
        else
        begin
            covered_end_reg <= covered_end_next;
            gap_sum_reg     <= gap_sum_next;
            hit_count_reg   <= hit_count_next;
            walk_done_reg   <= walk_done_next;
        end
    end

    // Snapshot taken with the finish request.
    assign len_now  = (we_reg > ws_reg) ? (we_reg - ws_reg) : '0;
    assign tail_now = (covered_end_reg < we_reg) ? (we_reg - covered_end_reg) : '0;

    // Uncovered length, clamped to the window length.
    assign unc_sum     = {1'b0, gap_snap_reg} + 33'(tail_reg);
    assign unc_clamped = (unc_sum > 33'(len_reg)) ? len_reg : unc_sum[PW-1:0];

    // Scaled covered length; its upper part seeds the divider remainder.
    assign prod = PROD_BITS'(covered_reg) * PROD_BITS'(PCT_SCALE);

    // Restoring division step: one quotient bit a cycle.
    assign trial    = {rem_reg, q_reg[PCT_BITS-1]};
    assign trial_ge = trial >= {1'b0, len_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.finish_take)
        begin
            gap_snap_reg <= gap_sum_reg;
            hit_snap_reg <= hit_count_reg;
            tail_reg     <= tail_now;
            len_reg      <= len_now;
        end
        if (cmd.calc)
        begin
            unc_reg     <= unc_clamped;
            covered_reg <= len_reg - unc_clamped;
        end
        if (cmd.mul)
        begin
            {rem_reg, q_reg} <= prod;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? PW'(trial - {1'b0, len_reg}) : trial[PW-1:0];
            q_reg   <= {q_reg[PCT_BITS-2:0], trial_ge};
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {1'b0, pct, 32'(len_reg), 32'(unc_reg), hit_snap_reg};
        end
    end

    // Division step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.mul)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + STEP_BITS'(1);
        end
    end

    assign status.div_last = (step_reg == STEP_BITS'(PCT_BITS - 1));
    assign pct             = (len_reg == '0) ? '0 : q_reg;
    assign window_start    = ws_reg;
    assign window_end      = we_reg;
    assign out_data        = out_data_reg;

    // Finish leaves a cleared walk behind.
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish_take && !cfg_wr.we) |=>
            (gap_sum_reg == '0 && hit_count_reg == '0 && !walk_done_reg
             && covered_end_reg == ws_reg))
        else $error("walk state not cleared by finish");

    // Once ended, the walk stays ended until finish or a register write.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_done_reg && !cmd.finish_take && !cfg_wr.we) |=> walk_done_reg)
        else $error("walk restarted without finish");

    // The percentage never exceeds one hundred.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (pct <= PCT_BITS'(PCT_SCALE)))
        else $error("coverage percentage out of range");

endmodule

/* hw/rtl/window_interval_coverage_unit.sv */
// Window interval coverage unit: read intervals sorted by start are taken one per
// cycle while no finish is under way, as requests with tuser low, and update the
// covered end, the uncovered gap sum and the count of reads that start or end in the
// window. A request with tuser high is a finish: once taken, it holds off further
// requests through the clamp and multiplier states, the one bit per cycle divider
// that forms the percentage and the load of the output register, and longer if the
// previous result has not yet been taken. Window registers are to be written
// through the APB port only while the unit is idle; the unit does not enforce this,
// and a write also restarts the walk. There is no clearing pass after reset.
module window_interval_coverage_unit #(
    parameter int unsigned POS_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    // Input requests.
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // read_start[31:0], read_end[63:32]
    input  logic          s_tuser,   // operation[0]
    // Result requests.
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // read_count[31:0], open_length[63:32],
                                     // window_length[95:64], coverage_percent[110:96]
    // Configuration port.
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import wicu_pkg::*;

    localparam int unsigned PW = (POS_BITS < 32) ? POS_BITS : 32;

    cfg_wr_t       cfg_wr;
    cmd_t          cmd;
    status_t       status;
    logic [PW-1:0] window_start;
    logic [PW-1:0] window_end;

    // APB write decode; the register index is the word address.
    assign pready       = 1'b1;
    assign cfg_wr.we    = psel && penable && pwrite && pready;
    assign cfg_wr.index = paddr[2];
    assign cfg_wr.data  = pwdata;

    // APB read back.
    assign prdata = (paddr[2] == REG_WINDOW_END) ? 32'(window_end) : 32'(window_start);

    wicu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_finish (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    wicu_dp #(
        .PW (PW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .cmd          (cmd),
        .status       (status),
        .read_start   (s_tdata[31:0]),
        .read_end     (s_tdata[63:32]),
        .window_start (window_start),
        .window_end   (window_end),
        .out_data     (m_tdata)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for window_interval_coverage_unit: streams mostly sorted read
// intervals and finish requests, tracks the expected totals and checks each result.
// Depends on wicu_pkg and the unit's top level only.

// One result request as it sits in m_tdata, lowest field last.
typedef struct packed {
    logic        spare;
    logic [14:0] coverage_percent;
    logic [31:0] window_length;
    logic [31:0] open_length;
    logic [31:0] read_count;
} coverage_totals_t;

// Tracks the walk over the window and holds the totals still to come out.
class coverage_tracker;
    logic [31:0]      win_start;
    logic [31:0]      win_end;
    logic [31:0]      cover_end;
    logic [31:0]      gap_total;
    logic [31:0]      hits;
    bit               walk_over;
    coverage_totals_t totals_due[$];
    int unsigned      fail_count;
    int unsigned      items_used;
    int unsigned      reads_taken;
    int unsigned      finishes;
    int unsigned      results_checked;

    function new();
        win_start = '0;
        win_end   = '0;
        restart_walk();
    endfunction

    function void restart_walk();
        cover_end = win_start;
        gap_total = '0;
        hits      = '0;
        walk_over = 1'b0;
    endfunction

    // A register write also restarts the walk.
    function void note_write(logic index, logic [31:0] value);
        if (index == wicu_pkg::REG_WINDOW_START)
            win_start = value;
        else
            win_end = value;
        restart_walk();
    endfunction

    function void note_request(logic op, logic [31:0] rs, logic [31:0] re);
        logic [32:0]      gap_sum;
        logic [63:0]      span;
        logic [63:0]      open;
        logic [63:0]      share;
        coverage_totals_t totals;
        if (op == 1'b0)
        begin
            items_used++;
            reads_taken++;
            // A read after the walk has ended is ignored until the finish.
            if (walk_over)
                return;
            if (rs > win_end)
            begin
                walk_over = 1'b1;
                return;
            end
            if (rs > cover_end)
            begin
                gap_sum   = {1'b0, gap_total} + {1'b0, rs - cover_end};
                gap_total = gap_sum[32] ? wicu_pkg::MAX32 : gap_sum[31:0];
            end
            if (re > cover_end)
                cover_end = re;
            if ((win_start <= rs && rs <= win_end) || (win_start <= re && re <= win_end))
                if (hits != wicu_pkg::MAX32)
                    hits++;
            return;
        end
        // Finish: the uncovered length is clamped to the window length.
        items_used++;
        finishes++;
        span = (win_end > win_start) ? 64'(win_end) - 64'(win_start) : 64'd0;
        open = 64'(gap_total);
        if (cover_end < win_end)
            open = open + 64'(win_end) - 64'(cover_end);
        if (open > span)
            open = span;
        share = (span != 0) ? ((span - open) * 64'(wicu_pkg::PCT_SCALE)) / span : 64'd0;
        totals.spare            = 1'b0;
        totals.read_count       = hits;
        totals.open_length      = open[31:0];
        totals.window_length    = span[31:0];
        totals.coverage_percent = share[14:0];
        totals_due = {totals_due, totals};
        restart_walk();
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    function void check_result(logic [111:0] word);
        coverage_totals_t got;
        coverage_totals_t want;
        got = coverage_totals_t'(word);
        if (totals_due.size() == 0)
        begin
            $error("result request with no finish outstanding: %h", word);
            fail_count++;
            return;
        end
        want = totals_due.pop_front();
        results_checked++;
        compare_field("read_count", want.read_count, got.read_count);
        compare_field("open_length", want.open_length, got.open_length);
        compare_field("window_length", want.window_length, got.window_length);
        compare_field("coverage_percent", 32'(want.coverage_percent),
                      32'(got.coverage_percent));
        compare_field("tdata padding", 32'(want.spare), 32'(got.spare));
    endfunction

    function int unsigned pending();
        return totals_due.size();
    endfunction
endclass

module tb_top;

    localparam logic        OP_READ        = 1'b0;
    localparam logic        OP_FINISH      = 1'b1;
    localparam int unsigned RANDOM_ITEMS   = 1400;
    // A finish keeps the unit busy; the quiet time is chosen to outlast it.
    localparam int unsigned QUIET_CYCLES   = 24;
    localparam int unsigned END_WAIT_LIMIT = 20000;
    // Run time limit in ns; the slowest correct run stays well under it.
    localparam longint      RUN_LIMIT_NS   = 64'd5_000_000;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [63:0]   s_tdata;   // read_start[31:0], read_end[63:32]
    logic          s_tuser;   // operation[0]
    logic          m_tvalid;
    logic          m_tready;
    logic [111:0]  m_tdata;   // read_count[31:0], open_length[63:32],
                              // window_length[95:64], coverage_percent[110:96]
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    coverage_tracker tracker;
    bit              steady;
    int unsigned     window_settings;

    window_interval_coverage_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Presents one request, idling at random first, and waits for acceptance.
    // Valid is left high so that back-to-back requests need no extra edge.
    task automatic send_request(input logic op, input logic [31:0] rs, input logic [31:0] re);
        while (!steady && $urandom_range(99, 0) < 22)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {re, rs};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_request(op, rs, re);
    endtask

    // Stops the request stream and lets the unit fall idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.note_write(index, value);
    endtask

    task automatic apb_read_check(input logic index, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {index, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $error("window register %0d readback: expected %h, got %h", index, want, prdata);
            tracker.fail_count++;
        end
    endtask

    // Writes the chosen window registers and reads each one back.
    task automatic set_window(input logic [31:0] ws, input logic [31:0] we,
                              input bit write_start, input bit write_end);
        if (write_start)
        begin
            apb_write(wicu_pkg::REG_WINDOW_START, ws);
            apb_read_check(wicu_pkg::REG_WINDOW_START, ws);
        end
        if (write_end)
        begin
            apb_write(wicu_pkg::REG_WINDOW_END, we);
            apb_read_check(wicu_pkg::REG_WINDOW_END, we);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        window_settings++;
    endtask

    // Chooses a new window: mostly narrow ones, with wide, inverted and edge cases.
    task automatic pick_window();
        logic [31:0] ws;
        logic [31:0] we;
        int unsigned pick;
        bit          write_start;
        bit          write_end;
        pick        = $urandom_range(99, 0);
        ws          = tracker.win_start;
        we          = tracker.win_end;
        write_start = 1'b1;
        write_end   = 1'b1;
        if (pick < 55)
        begin
            ws = $urandom;
            we = ws + $urandom_range(3000, 1);
        end
        else if (pick < 65)
        begin
            ws = $urandom_range(1000, 0);
            we = $urandom;
        end
        else if (pick < 75)
        begin
            ws = $urandom;
            we = ws - $urandom_range(100, 0);
        end
        else if (pick < 82)
        begin
            ws = '0;
            we = wicu_pkg::MAX32;
        end
        else if (pick < 88)
        begin
            ws = wicu_pkg::MAX32 - $urandom_range(500, 0);
            we = wicu_pkg::MAX32;
        end
        else if (pick < 94)
        begin
            ws        = we - $urandom_range(2000, 0);
            write_end = 1'b0;
        end
        else
        begin
            we          = ws + $urandom_range(2000, 0);
            write_start = 1'b0;
        end
        set_window(ws, we, write_start, write_end);
    endtask

    // One walk: mostly reads sorted by start around the window, some with
    // reads out of order or reversed, some pure noise; always closed by a finish.
    task automatic random_walk();
        logic [31:0] span;
        logic [31:0] reach;
        logic [31:0] pos;
        logic [31:0] rs;
        logic [31:0] re;
        int unsigned count;
        int unsigned style;
        int unsigned i;
        span  = (tracker.win_end > tracker.win_start) ?
                tracker.win_end - tracker.win_start : 32'd64;
        reach = span / 4 + 1;
        count = $urandom_range(16, 0);
        style = $urandom_range(99, 0);
        pos   = (tracker.win_start > reach) ?
                tracker.win_start - $urandom_range(reach, 0) : 32'd0;
        for (i = 0; i < count; i++)
        begin
            pos = pos + $urandom_range(reach, 0);
            rs  = pos;
            re  = pos + $urandom_range(span / 3 + 1, 0);
            if (style >= 90)
            begin
                rs = $urandom;
                re = $urandom;
            end
            else if (style >= 75 && $urandom_range(4, 0) == 0)
            begin
                if ($urandom_range(1, 0) == 1)
                begin
                    rs = re;
                    re = pos;
                end
                else
                    rs = pos - $urandom_range(reach, 0);
            end
            send_request(OP_READ, rs, re);
        end
        send_request(OP_FINISH, $urandom, $urandom);
    endtask

    // Result side: samples at the edge, then stalls at random.
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            m_tready <= steady || ($urandom_range(99, 0) >= 22);
        end
    end

    // Main sequence.
    initial
    begin
        int unsigned random_floor;
        int unsigned waited;
        tracker  = new();
        steady   <= 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_READ;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Finish on the empty window left by reset.
        send_request(OP_FINISH, '0, '0);

        // Full-range window: reversed reads drive the gap sum into saturation,
        // then one read covering everything gives full coverage.
        settle();
        set_window('0, wicu_pkg::MAX32, 1'b1, 1'b1);
        send_request(OP_READ, wicu_pkg::MAX32, '0);
        send_request(OP_READ, wicu_pkg::MAX32, '0);
        send_request(OP_FINISH, '0, '0);
        send_request(OP_READ, '0, wicu_pkg::MAX32);
        send_request(OP_FINISH, wicu_pkg::MAX32, wicu_pkg::MAX32);

        // Ordinary walk: a read before the window, overlaps, a read starting on
        // the window end, the read that ends the walk and one that is ignored.
        settle();
        set_window(32'd1000, 32'd2000, 1'b1, 1'b1);
        send_request(OP_READ, 32'd100, 32'd200);
        send_request(OP_READ, 32'd900, 32'd1100);
        send_request(OP_READ, 32'd1200, 32'd1500);
        send_request(OP_READ, 32'd1400, 32'd1600);
        send_request(OP_READ, 32'd2000, 32'd2050);
        send_request(OP_READ, 32'd2500, 32'd2600);
        send_request(OP_READ, 32'd1700, 32'd1900);
        send_request(OP_FINISH, '0, '0);

        // Inverted window.
        settle();
        set_window(32'd5000, 32'd10, 1'b1, 1'b1);
        send_request(OP_READ, 32'd0, 32'd20);
        send_request(OP_FINISH, '0, '0);

        // Empty window at the top of the position range.
        settle();
        set_window(wicu_pkg::MAX32, wicu_pkg::MAX32, 1'b1, 1'b1);
        send_request(OP_READ, wicu_pkg::MAX32 - 1, wicu_pkg::MAX32);
        send_request(OP_FINISH, '0, '0);

        // A reversed read followed by one ending on the window end.
        settle();
        set_window(32'd0, 32'd100, 1'b1, 1'b1);
        send_request(OP_READ, 32'd60, 32'd20);
        send_request(OP_READ, 32'd30, 32'd100);
        send_request(OP_FINISH, '0, '0);

        // Random walks, with a stretch in the middle where neither side idles.
        random_floor = tracker.items_used;
        while (tracker.items_used < random_floor + RANDOM_ITEMS)
        begin
            steady <= (tracker.items_used >= random_floor + 500 &&
                       tracker.items_used <  random_floor + 800);
            if ($urandom_range(99, 0) < 40)
            begin
                settle();
                pick_window();
            end
            random_walk();
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;

        // Drain, then watch for stray results.
        waited = 0;
        while (tracker.pending() != 0 && waited < END_WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (QUIET_CYCLES) @(posedge clk);
        if (tracker.pending() != 0)
        begin
            $error("%0d expected results never arrived", tracker.pending());
            tracker.fail_count += tracker.pending();
        end

        $display("Streamed %0d read and %0d finish requests over %0d window settings.",
                 tracker.reads_taken, tracker.finishes, window_settings);
        $display("Checked %0d result requests field by field.", tracker.results_checked);
        if (tracker.fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard limit on the run time.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/wicu_pkg.sv
hw/rtl/wicu_ctrl.sv
hw/rtl/wicu_dp.sv
hw/rtl/window_interval_coverage_unit.sv
dv/tb_top.sv
